### rtl/hff_pkg.sv
package hff_pkg;

   localparam int MAX_WIDTH  = 48;
   localparam int CNT_BITS   = 7;
   localparam int NDIG_BITS  = 5;
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = $clog2(QDEPTH);
   localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_X_UP  = 7'h58;
   localparam logic [6:0] CH_X_LO  = 7'h78;

   localparam logic [6:0] UPPER_DIGITS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46};
   localparam logic [6:0] LOWER_DIGITS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66};

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_PFX0,
      PH_PFXX,
      PH_ZERO,
      PH_DIGIT,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [63:0]          value;
      logic [NDIG_BITS-1:0] ndig;
      logic [CNT_BITS-1:0]  pad;
      logic                 upper;
      logic                 prefix;
      logic                 has_lead;
      logic                 has_zero;
      logic                 has_trail;
   } desc_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
      hex_char = upper ? UPPER_DIGITS[nib] : LOWER_DIGITS[nib];
   endfunction

endpackage

### rtl/hff_front.sv
module hff_front (
   input  logic             push,
   output logic             full,
   input  logic [63:0]      req_value,
   input  logic             req_long_value,
   input  logic             req_uppercase,
   input  logic             req_alt_prefix,
   input  logic             req_pad_zeros,
   input  logic             req_left_justify,
   input  logic [5:0]       req_field_width,
   input  logic             q_full,
   output logic             q_push,
   output hff_pkg::desc_type q_desc
);

   logic [63:0]                   value_m;
   logic [hff_pkg::NDIG_BITS-1:0] ndig;
   logic [hff_pkg::CNT_BITS-1:0]  width_sat;
   logic [hff_pkg::CNT_BITS-1:0]  used;
   logic [hff_pkg::CNT_BITS-1:0]  pad;

   assign value_m = req_long_value ? req_value : {32'h0, req_value[31:0]};

   // highest nonzero nibble sets the digit count; zero still gives one digit
   always_comb begin
      ndig = hff_pkg::NDIG_BITS'(1);
      for (int i = 1; i < 16; i++) begin
         if (value_m[4*i +: 4] != 4'h0) ndig = hff_pkg::NDIG_BITS'(i + 1);
      end
   end

   always_comb begin
      if ({1'b0, req_field_width} > hff_pkg::CNT_BITS'(hff_pkg::MAX_WIDTH))
         width_sat = hff_pkg::CNT_BITS'(hff_pkg::MAX_WIDTH);
      else
         width_sat = hff_pkg::CNT_BITS'(req_field_width);
      used = hff_pkg::CNT_BITS'(ndig) + (req_alt_prefix ? hff_pkg::CNT_BITS'(2)
                                                        : hff_pkg::CNT_BITS'(0));
      pad  = (width_sat > used) ? width_sat - used : '0;
   end

   always_comb begin
      q_desc.value     = value_m;
      q_desc.ndig      = ndig;
      q_desc.pad       = pad;
      q_desc.upper     = req_uppercase;
      q_desc.prefix    = req_alt_prefix;
      q_desc.has_zero  = req_pad_zeros && (pad != '0);
      q_desc.has_lead  = !req_pad_zeros && !req_left_justify && (pad != '0);
      q_desc.has_trail = !req_pad_zeros && req_left_justify && (pad != '0);
   end

   assign full   = q_full;
   assign q_push = push && !q_full;

endmodule

### rtl/hff_queue.sv
module hff_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hff_pkg::desc_type wr_desc,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output hff_pkg::desc_type rd_desc
);

   hff_pkg::desc_type                entry_ff [hff_pkg::QDEPTH];
   logic [hff_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [hff_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [hff_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full    = (count_ff == hff_pkg::QCNT_BITS'(hff_pkg::QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == hff_pkg::QPTR_BITS'(hff_pkg::QDEPTH - 1))
                               ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == hff_pkg::QPTR_BITS'(hff_pkg::QDEPTH - 1))
                               ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= wr_desc;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hff_pkg::QCNT_BITS'(hff_pkg::QDEPTH))
      else $error("queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == hff_pkg::QCNT_BITS'(hff_pkg::QDEPTH))
      |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/hff_back.sv
module hff_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  hff_pkg::desc_type q_desc,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [6:0]        rsp_out_char,
   output logic              rsp_last
);

   hff_pkg::phase_type            state_ff, state_in;
   hff_pkg::phase_type            ph_eff;
   hff_pkg::phase_type            ph_next;
   logic [hff_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [hff_pkg::CNT_BITS-1:0]  ph_len;
   logic                          ph_done;
   logic                          advance;
   logic                          ch_last;
   logic [6:0]                    ch;
   logic [3:0]                    nib_idx;
   logic [63:0]                   shifted;
   logic [6:0]                    out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_valid_ff, out_valid_in;

   function automatic hff_pkg::phase_type follow(input hff_pkg::phase_type ph,
                                                 input hff_pkg::desc_type d);
      hff_pkg::phase_type after_pfx;
      after_pfx = d.has_zero ? hff_pkg::PH_ZERO : hff_pkg::PH_DIGIT;
      case (ph)
         hff_pkg::PH_START: follow = d.has_lead ? hff_pkg::PH_LEAD :
                                     d.prefix   ? hff_pkg::PH_PFX0 : after_pfx;
         hff_pkg::PH_LEAD:  follow = d.prefix ? hff_pkg::PH_PFX0 : after_pfx;
         hff_pkg::PH_PFX0:  follow = hff_pkg::PH_PFXX;
         hff_pkg::PH_PFXX:  follow = after_pfx;
         hff_pkg::PH_ZERO:  follow = hff_pkg::PH_DIGIT;
         hff_pkg::PH_DIGIT: follow = d.has_trail ? hff_pkg::PH_TRAIL : hff_pkg::PH_START;
         default:           follow = hff_pkg::PH_START;
      endcase
   endfunction

   assign ph_eff  = (state_ff == hff_pkg::PH_START) ? follow(hff_pkg::PH_START, q_desc)
                                                     : state_ff;
   assign advance = !q_empty && (!out_valid_ff || pop);

   always_comb begin
      case (ph_eff)
         hff_pkg::PH_LEAD, hff_pkg::PH_ZERO, hff_pkg::PH_TRAIL: ph_len = q_desc.pad;
         hff_pkg::PH_DIGIT: ph_len = hff_pkg::CNT_BITS'(q_desc.ndig);
         default:           ph_len = hff_pkg::CNT_BITS'(1);
      endcase
   end

   assign ph_done = (cnt_ff == ph_len - 1'b1);
   assign ph_next = follow(ph_eff, q_desc);
   assign ch_last = ph_done && (ph_next == hff_pkg::PH_START);

   // digits go out most significant first
   assign nib_idx = 4'(q_desc.ndig - 1'b1) - 4'(cnt_ff);
   assign shifted = q_desc.value >> {nib_idx, 2'b00};

   always_comb begin
      case (ph_eff)
         hff_pkg::PH_LEAD, hff_pkg::PH_TRAIL: ch = hff_pkg::CH_SPACE;
         hff_pkg::PH_PFX0, hff_pkg::PH_ZERO:  ch = hff_pkg::CH_ZERO;
         hff_pkg::PH_PFXX: ch = q_desc.upper ? hff_pkg::CH_X_UP : hff_pkg::CH_X_LO;
         hff_pkg::PH_DIGIT: ch = hff_pkg::hex_char(shifted[3:0], q_desc.upper);
         default:          ch = hff_pkg::CH_SPACE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (advance) begin
         if (ph_done) begin
            state_in = ph_next;
            cnt_in   = '0;
         end else begin
            state_in = ph_eff;
            cnt_in   = cnt_ff + 1'b1;
         end
      end
   end

   // outputs
   always_comb begin
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_char_in  = ch;
         out_last_in  = ch_last;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hff_pkg::PH_START;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign q_pop        = advance && ch_last;
   assign empty        = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = out_last_ff;

`ifndef ASSERT_OFF
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && ch_last) |=> (state_ff == hff_pkg::PH_START && cnt_ff == '0))
      else $error("sequencer did not return to start after last character");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < hff_pkg::CNT_BITS'(hff_pkg::MAX_WIDTH))
      else $error("phase counter past field limit");
   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      (advance && ph_eff == hff_pkg::PH_DIGIT) |->
      ((ch >= 7'h30 && ch <= 7'h39) || (ch >= 7'h41 && ch <= 7'h46) ||
       (ch >= 7'h61 && ch <= 7'h66)))
      else $error("digit phase produced a non-hex character");
`endif

endmodule

### rtl/hex_field_formatter_top.sv
// Hex field formatter: formats one 64-bit or 32-bit value as a padded hex
// field and returns it one ASCII character per request on the rsp_ side,
// with rsp_last on the final character. A request is taken on push while
// full is low; a two-entry queue after the classifier lets requests enter
// back to back while earlier fields are still going out. The character
// sequencer emits one character per cycle while a request waits and pop
// drains the output; a field is max(width, digits + prefix) characters;
// width is field_width capped at 48, digits 1 to 16, prefix 2 on alt_prefix.
module hex_field_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_value,
   input  logic        req_long_value,
   input  logic        req_uppercase,
   input  logic        req_alt_prefix,
   input  logic        req_pad_zeros,
   input  logic        req_left_justify,
   input  logic [5:0]  req_field_width,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_last
);

   hff_pkg::desc_type wr_desc;
   hff_pkg::desc_type rd_desc;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   hff_front u_front (
      .push             (push),
      .full             (full),
      .req_value        (req_value),
      .req_long_value   (req_long_value),
      .req_uppercase    (req_uppercase),
      .req_alt_prefix   (req_alt_prefix),
      .req_pad_zeros    (req_pad_zeros),
      .req_left_justify (req_left_justify),
      .req_field_width  (req_field_width),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (wr_desc)
   );

   hff_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_desc (wr_desc),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_desc (rd_desc)
   );

   hff_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_desc       (rd_desc),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule
